// ===== src/ccs_pkg.sv =====
// Shared types and constants for the C comment stripper.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccs_pkg;

    // Default depth of the queue between the classifier and the output stage
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    // One classified input: one or two output bytes
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two;
    } t_entry;

    // Queue status seen by the top level and the back part
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== src/ccs_front.sv =====
// Front part: scan state machine that classifies each input byte.
// Depends on ccs_pkg (t_entry).
`default_nettype none

module ccs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_end_of_text,
    output logic                o_push,
    output ccs_pkg::t_entry     o_entry
);
    import ccs_pkg::*;

    // scan modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_QUOTE  = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;
    localparam logic [2:0] MODE_LINE   = 3'd5;

    // characters of interest
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;

    logic [2:0] r_mode, n_mode;
    logic       r_star, n_star;
    logic [7:0] r_prior, r_prior2;

    logic [1:0] v_cnt;
    logic [7:0] v_b0, v_b1;
    logic [7:0] b;
    logic       escaped;

    assign b       = i_text_byte;
    assign escaped = (r_prior == CH_BSLASH) && (r_prior2 != CH_BSLASH);

    // next state and emitted bytes for the current byte
    always_comb begin
        n_mode = r_mode;
        n_star = r_star;
        v_cnt  = 2'd0;
        v_b0   = b;
        v_b1   = b;
        case (r_mode)
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    v_b0   = CH_NL;
                    v_cnt  = 2'd1;
                    n_mode = MODE_LINE;
                end else if (b == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                    n_star = 1'b0;
                end else begin
                    // held slash first, then the byte as normal text
                    v_b0   = CH_SLASH;
                    v_b1   = b;
                    v_cnt  = 2'd2;
                    n_mode = (b == CH_DQUOTE) ? MODE_QUOTE : MODE_NORMAL;
                end
            end
            MODE_QUOTE: begin
                v_b0  = b;
                v_cnt = 2'd1;
                if (b == CH_APOS) begin
                    n_mode = MODE_NORMAL;
                end else if ((b == CH_DQUOTE && !escaped) || b == CH_NL) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    n_mode = MODE_STRING;
                end
            end
            MODE_STRING: begin
                v_b0  = b;
                v_cnt = 2'd1;
                if ((b == CH_DQUOTE && !escaped) || b == CH_NL) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (r_star && b == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                    n_star = 1'b0;
                end else begin
                    n_star = (b == CH_STAR);
                end
            end
            MODE_LINE: begin
                if (b == CH_NL) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (b == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else begin
                    v_b0   = b;
                    v_cnt  = 2'd1;
                    n_mode = (b == CH_DQUOTE) ? MODE_QUOTE : MODE_NORMAL;
                end
            end
        endcase

        // end of text flushes a pending slash and leaves every mode but block
        if (i_end_of_text) begin
            if (n_mode == MODE_SLASH) begin
                v_b0  = CH_SLASH;
                v_cnt = 2'd1;
            end
            if (n_mode != MODE_BLOCK) begin
                n_mode = MODE_NORMAL;
            end
        end
    end

    assign o_push              = i_accept && (v_cnt != 2'd0);
    assign o_entry.first_byte  = v_b0;
    assign o_entry.second_byte = v_b1;
    assign o_entry.two         = v_cnt[1];

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_star   <= 1'b0;
            r_prior  <= 8'd0;
            r_prior2 <= 8'd0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_star   <= n_star;
            r_prior  <= b;
            r_prior2 <= r_prior;
        end
    end

endmodule

`default_nettype wire

// ===== src/ccs_queue.sv =====
// Short FIFO of classified entries between the front and back parts.
// Depends on ccs_pkg (t_entry, t_q_status).
`default_nettype none

module ccs_queue #(
    parameter int DEPTH = ccs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ccs_pkg::t_entry i_entry,
    input  wire logic           i_pop,
    output ccs_pkg::t_entry     o_head,
    output ccs_pkg::t_q_status  o_status
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ccs_back.sv =====
// Back part: output register that sends each entry as one or two transactions.
// Depends on ccs_pkg (t_entry, t_q_status).
`default_nettype none

module ccs_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ccs_pkg::t_entry    i_head,
    input  wire ccs_pkg::t_q_status i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_out_byte,
    output logic                    o_run_last
);
    import ccs_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pend;
    logic [7:0] r_second;
    logic       load_ok;

    // output register is free or being taken this cycle
    assign load_ok = !r_valid || !i_stall;
    assign o_pop   = load_ok && !r_pend && !i_status.empty;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load_ok) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_status.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_head.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            if (r_pend) begin
                r_byte <= r_second;
                r_last <= 1'b1;
            end else begin
                r_byte   <= i_head.first_byte;
                r_last   <= !i_head.two;
                r_second <= i_head.second_byte;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;

endmodule

`default_nettype wire

// ===== src/c_comment_stripper.sv =====
// C comment stripper: removes block and line comments from a byte stream.
// Uses ccs_pkg, ccs_front, ccs_queue and ccs_back.
//
// Input channel (i_valid / o_stall): one source byte per transaction, with
// i_end_of_text marking the final byte of a text. Output channel
// (o_valid / i_stall): the comment-free bytes; o_run_last is set on the
// last byte caused by one input byte.
// Throughput: one input byte per cycle while o_stall is low. An input
// byte yields zero, one or two output bytes; a two-byte result (a held
// slash plus the byte after it) leaves the single output register as two
// transactions, so the sustained rate is set by that register: one output
// byte per cycle while i_stall is low. Each result is classified by the
// front part, then registered in the queue and then in the output register.
// A slash is held back until the next byte (or end of text) decides it.
// Reset (synchronous, active low) returns the scanner to plain text and
// empties the queue and output register. When the receiver stalls, the
// output holds; the queue fills and o_stall rises once it is full.
`default_nettype none

module c_comment_stripper #(
    parameter int QUEUE_DEPTH = ccs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);
    import ccs_pkg::*;

    t_entry    push_entry, head_entry;
    t_q_status q_status;
    logic      accept, push, pop;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !o_stall;

    // classify incoming bytes
    ccs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // decoupling queue
    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    // emit output transactions
    ccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_entry),
        .i_status   (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

`default_nettype wire

// ===== src/ccs_checker.sv =====
// Port-level checks for the C comment stripper, bound to the top level.
// Depends on c_comment_stripper's port list only.
`default_nettype none

module ccs_props (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [7:0] i_text_byte,
    input wire logic       i_end_of_text,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_run_last
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled output transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte) && $stable(o_run_last)))
        else $error("stalled output changed");

    // only a held slash precedes another byte of the same input
    a_first_is_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_last) |-> (o_out_byte == 8'h2F))
        else $error("non-final byte is not a slash");

    // second byte of a pair follows at once
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_run_last) |=> o_valid)
        else $error("second byte of a pair missing");

endmodule

bind c_comment_stripper ccs_props u_ccs_props (.*);

`default_nettype wire
